>>> sv/grr_pkg.sv
package grr_pkg;

    localparam int GRR_MAX_GROUP = 16;
    localparam int VALUE_W       = 32;
    localparam int GS_W          = 5;
    localparam logic [GS_W-1:0] GS_RESET = 5'd3;

    // Per-cycle command shared by every cell in the row
    typedef struct packed {
        logic shift_in;    // take the neighbor on the input side
        logic shift_down;  // take the neighbor on the side away from cell 0
    } grr_cell_ctl_t;

endpackage

>>> sv/group_reverse_reorder.sv
// group_reverse_reorder: reverse a stream of signed values in groups of K.
//
// Channels:
//   input  - value / final_element with in_valid / in_ready.
//   output - value_res / run_end / sequence_end with out_valid / out_ready.
//   config - cfg_data (group_size) with cfg_valid / cfg_ready; write only
//            while the block is idle. Zero acts as 1, values above
//            MAX_GROUP act as MAX_GROUP.
// Operation: each item is pushed into a row of MAX_GROUP cells. When the row
// holds K or more items the group drains newest first; when the final item arrives
// short of K the partial group drains in arrival order.
// Timing: an item that completes a run starts its drain; the output register
// then takes one result per cycle whenever out_ready is high or it is empty.
// The input is held off (in_ready low) while a run drains through the one output,
// so no new item is taken until the last result of the run is in the output register.
// Stalls: when out_ready is low the output register holds its item and the
// drain pauses; an item may still be accepted while the last result of a run
// waits in the output register.
// Reset: clears the fill count, the drain state and the output valid, and
// loads group_size with 3. Cell contents are not cleared.
module group_reverse_reorder #(
    parameter int MAX_GROUP = grr_pkg::GRR_MAX_GROUP
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [grr_pkg::VALUE_W-1:0]  value,
    input  logic                                final_element,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [grr_pkg::VALUE_W-1:0]  value_res,
    output logic                                run_end,
    output logic                                sequence_end,
    // config channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [grr_pkg::GS_W-1:0]            cfg_data
);
    import grr_pkg::*;

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_GROUP);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LIFO = 3'b010,
        ST_FIFO = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   seq_reg, seq_next;
    logic [GS_W-1:0]        gs_reg, gs_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] value_res_reg, value_res_next;
    logic                   run_end_reg, run_end_next;
    logic                   seq_end_reg, seq_end_next;

    logic signed [VALUE_W-1:0] cell_q [MAX_GROUP];
    grr_cell_ctl_t          cell_ctl;

    logic                   in_acc;
    logic                   out_free;
    logic [CW-1:0]          k_eff;
    logic [CW-1:0]          n_new;
    logic [IW-1:0]          fifo_idx;
    logic                   last_step;

    // ---------------------------------------------------------------
    // Cell row: cell 0 holds the newest item
    // ---------------------------------------------------------------
    for (genvar i = 0; i < MAX_GROUP; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] lower;
        logic signed [VALUE_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = value;
        end
        else
        begin : g_mid_lo
            assign lower = cell_q[i-1];
        end

        if (i == MAX_GROUP - 1)
        begin : g_last
            assign upper = cell_q[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_q[i+1];
        end

        grr_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .from_lower (lower),
            .from_upper (upper),
            .data       (cell_q[i])
        );
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Clamp the group size into 1..MAX_GROUP
    always_comb
    begin
        if (gs_reg == '0)
        begin
            k_eff = CNT_ONE;
        end
        else if (int'(gs_reg) > MAX_GROUP)
        begin
            k_eff = CNT_MAX;
        end
        else
        begin
            k_eff = CW'(gs_reg);
        end
    end

    assign n_new     = (cnt_reg < CNT_MAX) ? cnt_reg + CNT_ONE : cnt_reg;
    assign fifo_idx  = IW'(cnt_reg - CNT_ONE);
    assign last_step = (cnt_reg == CNT_ONE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        seq_next       = seq_reg;
        gs_next        = gs_reg;
        out_valid_next = out_valid_reg;
        value_res_next = value_res_reg;
        run_end_next   = run_end_reg;
        seq_end_next   = seq_end_reg;
        cell_ctl       = '0;

        if (cfg_valid && cfg_ready)
        begin
            gs_next = cfg_data;
        end

        // drop the output item once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cell_ctl.shift_in = (cnt_reg < CNT_MAX);
                    cnt_next          = n_new;
                    seq_next          = final_element;
                    if (n_new >= k_eff)
                    begin
                        state_next = ST_LIFO;
                    end
                    else if (final_element)
                    begin
                        state_next = ST_FIFO;
                    end
                end
            end
            ST_LIFO:
            begin
                if (out_free)
                begin
                    value_res_next      = cell_q[0];
                    run_end_next        = last_step;
                    seq_end_next        = last_step && seq_reg;
                    out_valid_next      = 1'b1;
                    cell_ctl.shift_down = 1'b1;
                    cnt_next            = cnt_reg - CNT_ONE;
                    if (last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIFO:
            begin
                if (out_free)
                begin
                    // oldest of the remaining items sits deepest in the row
                    value_res_next = cell_q[fifo_idx];
                    run_end_next   = last_step;
                    seq_end_next   = last_step;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg - CNT_ONE;
                    if (last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seq_reg       <= 1'b0;
            gs_reg        <= GS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seq_reg       <= seq_next;
            gs_reg        <= gs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload: no reset
    always_ff @(posedge clk)
    begin
        value_res_reg <= value_res_next;
        run_end_reg   <= run_end_next;
        seq_end_reg   <= seq_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign value_res    = value_res_reg;
    assign run_end      = run_end_reg;
    assign sequence_end = seq_end_reg;

endmodule

>>> sv/grr_cell.sv
module grr_cell (
    input  logic                         clk,
    input  grr_pkg::grr_cell_ctl_t       ctl,
    input  logic signed [grr_pkg::VALUE_W-1:0] from_lower,
    input  logic signed [grr_pkg::VALUE_W-1:0] from_upper,
    output logic signed [grr_pkg::VALUE_W-1:0] data
);
    import grr_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    // Push away from cell 0 on a store, pull toward cell 0 on a newest-first drain
    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_in)
        begin
            data_next = from_lower;
        end
        else if (ctl.shift_down)
        begin
            data_next = from_upper;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> tb/group_reverse_reorder_tb.sv
module group_reverse_reorder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grr_pkg::*;

    // Upper bound on the whole run; the slowest legal run is far below this
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to let pass after the last result before touching the register
    localparam int SETTLE      = 4;
    // Length of the one long receiver hold-off
    localparam int STALL_LEN   = 300;
    localparam int PHASE_ITEMS = 12;

    typedef struct {
        logic signed [VALUE_W-1:0] val;
        logic                      fin;
    } elem_t;

    typedef struct {
        logic signed [VALUE_W-1:0] val;
        logic                      run_end;
        logic                      seq_end;
    } reorder_res_t;

    // Clock, reset and DUT-facing signals; the inputs the bench drives start known
    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value         = '0;
    logic                      final_element = 1'b0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    logic signed [VALUE_W-1:0] value_res;
    logic                      run_end;
    logic                      sequence_end;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [GS_W-1:0]           cfg_data      = '0;

    // Elements waiting to be offered, and the reordered values still owed
    elem_t        pending_elems[$];
    reorder_res_t owed_results[$];

    // Shadow of the block: the group being collected and the size register
    logic signed [VALUE_W-1:0] row_vals [GRR_MAX_GROUP];
    int                        row_fill       = 0;
    logic [GS_W-1:0]           cur_group_size = GS_RESET;

    // Bookkeeping for the processes, most of it shared between them
    int   in_taken      = 0;
    int   res_count     = 0;
    int   error_count   = 0;
    int   cycle_count   = 0;
    int   size_writes   = 0;
    bit   gaps_on       = 1'b0;
    bit   stall_arm     = 1'b0;
    bit   stall_fired   = 1'b0;
    int   stall_left    = 0;

    // Driver state
    bit    drv_busy       = 1'b0;
    int    drv_gap        = 0;
    int    drv_taken_seen = 0;
    elem_t drv_next;

    // Receiver state
    int rx_wait = 0;
    int rx_seen = 0;

    reorder_res_t got;

    group_reverse_reorder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .final_element (final_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value_res     (value_res),
        .run_end       (run_end),
        .sequence_end  (sequence_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before the next item on either side; zero in burst phases
    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(0, 18)) : 0;
    endfunction

    // Mostly random words, with the corners mixed in often
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Collect one accepted element and queue whatever it releases.
    // Zero acts as a size of one; sizes past the row depth saturate.
    task automatic track_group(input logic signed [VALUE_W-1:0] v, input logic fin);
        int k;
        int n;
        reorder_res_t r;
        k = int'(cur_group_size);
        if (k == 0)
            k = 1;
        if (k > GRR_MAX_GROUP)
            k = GRR_MAX_GROUP;
        if (row_fill < GRR_MAX_GROUP)
        begin
            row_vals[row_fill] = v;
            row_fill++;
        end
        n = row_fill;
        if (n >= k)
        begin
            // full group: newest first, sequence end only if this is the final element
            for (int i = 0; i < n; i++)
            begin
                r.val     = row_vals[n - 1 - i];
                r.run_end = (i == n - 1);
                r.seq_end = (i == n - 1) && fin;
                owed_results.push_back(r);
            end
            row_fill = 0;
        end
        else if (fin)
        begin
            // short tail of the sequence: arrival order
            for (int i = 0; i < n; i++)
            begin
                r.val     = row_vals[i];
                r.run_end = (i == n - 1);
                r.seq_end = (i == n - 1);
                owed_results.push_back(r);
            end
            row_fill = 0;
        end
    endtask

    // Driver: advance to the next element at the falling edge once the
    // current one was taken, honoring the drawn gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken != drv_taken_seen)
            begin
                drv_taken_seen = in_taken;
                drv_busy       = 1'b0;
                drv_gap        = draw_gap();
            end
            if (!drv_busy)
            begin
                if (drv_gap != 0)
                    drv_gap--;
                else if (pending_elems.size() != 0)
                begin
                    drv_next = pending_elems.pop_front();
                    value         <= drv_next.val;
                    final_element <= drv_next.fin;
                    drv_busy      = 1'b1;
                end
            end
            in_valid <= drv_busy;
        end
    end

    // Long hold-off of the receiver, fired once when the stimulus arms it
    always @(negedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_arm && !stall_fired)
        begin
            stall_left  <= STALL_LEN;
            stall_fired <= 1'b1;
        end
    end

    // Receiver: draw a fresh wait after each taken result; drop ready
    // for the whole long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_count != rx_seen)
            begin
                rx_seen = res_count;
                rx_wait = draw_gap();
            end
            if (stall_left != 0)
                out_ready <= 1'b0;
            else if (rx_wait != 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted element, compare every taken result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                in_taken++;
                track_group(value, final_element);
            end
            if (out_valid && out_ready)
            begin
                res_count++;
                if (owed_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result value=%0d run_end=%0b sequence_end=%0b",
                             $time, value_res, run_end, sequence_end);
                end
                else
                begin
                    got = owed_results.pop_front();
                    if (value_res !== got.val || run_end !== got.run_end ||
                        sequence_end !== got.seq_end)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected value=%0d run_end=%0b sequence_end=%0b",
                                 $time, got.val, got.run_end, got.seq_end);
                        $display("%0t:          actual   value=%0d run_end=%0b sequence_end=%0b",
                                 $time, value_res, run_end, sequence_end);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results still owed", $time, owed_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic offer(input logic signed [VALUE_W-1:0] v, input logic fin);
        elem_t e;
        e.val = v;
        e.fin = fin;
        pending_elems.push_back(e);
    endtask

    // Hold until every element is taken and every owed result has come,
    // then give the block a few cycles to settle.
    task automatic drain_phase();
        while (pending_elems.size() != 0 || drv_busy || owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write over the config channel; only called with the block idle
    task automatic write_group_size(input logic [GS_W-1:0] gs);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= gs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_group_size = gs;
        size_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Queue whole sequences until the phase has enough elements; the last
    // one is sometimes cut short so the next setting starts mid-group.
    task automatic fill_sequences(input int target, input int k);
        int count;
        int len;
        bit cut;
        count = 0;
        while (count < target)
        begin
            len = $urandom_range(1, 2 * k + 3);
            cut = (count + len >= target) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
                offer(pick_value(), (i == len - 1) && !cut);
            count += len;
        end
    endtask

    int phase_sizes[8] = '{1, 16, 31, 4, 3, 9, 16, 5};

    initial
    begin
        // Reset once, released at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size of three, full groups, short tails, lone final
        offer(32'sh7fff_ffff, 1'b0);
        offer(32'sh8000_0000, 1'b0);
        offer(32'sh0000_0000, 1'b0);
        offer(-32'sd1, 1'b0);
        offer(32'sd1, 1'b1);
        offer(32'sh1234_5678, 1'b1);
        offer(32'sh0bad_f00d, 1'b0);
        offer(-32'sd7, 1'b0);
        offer(32'sh7654_3210, 1'b1);
        drain_phase();

        // Lower the size while five elements are held; the next one flushes all six
        write_group_size(5'd8);
        for (int i = 0; i < 5; i++)
            offer(pick_value(), 1'b0);
        drain_phase();
        write_group_size(5'd2);
        offer(32'sh0f0f_0f0f, 1'b0);
        drain_phase();

        // Size zero passes each element through alone
        write_group_size(5'd0);
        offer(32'sh5555_5555, 1'b0);
        offer(32'shaaaa_aaaa, 1'b1);
        drain_phase();

        // Random phases over several sizes, saturating and extreme ones included
        phase_sizes[7] = $urandom_range(1, GRR_MAX_GROUP);
        foreach (phase_sizes[p])
        begin
            gaps_on = (p % 3 != 2);
            write_group_size(phase_sizes[p][GS_W-1:0]);
            if (p == 6)
            begin
                // burst into a stalled receiver so the row fills and input backs up
                gaps_on   = 1'b0;
                stall_arm = 1'b1;
            end
            fill_sequences((p == 6) ? 2 * PHASE_ITEMS : PHASE_ITEMS,
                           phase_sizes[p] > GRR_MAX_GROUP ? GRR_MAX_GROUP : phase_sizes[p]);
            drain_phase();
        end

        // Close any group left open, then let stray results show up
        offer(pick_value(), 1'b1);
        drain_phase();
        repeat (20) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, owed_results.size());
        end

        $display("Fed %0d elements and checked %0d reordered results across %0d size writes,",
                 in_taken, res_count, size_writes);
        $display("covering sizes 0, 1, 16 and 31, a mid-group shrink and a long output stall.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/grr_pkg.sv
sv/grr_cell.sv
sv/group_reverse_reorder.sv
tb/group_reverse_reorder_tb.sv
